### rtl/assert_macros.svh
// Assertion macros for the checker file of the hasher.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define S256_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hasher check failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define S256_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hasher check failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define S256_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hasher check failed");

`endif

### rtl/s256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
// No dependencies; used by the top level, the front end, the core and the scoreboard.
`default_nettype none

package s256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

### rtl/s256_if.sv
// Handshake channels of the hasher: message bytes in, digest words out.
// Depends on nothing but the valid/ready convention.
`default_nettype none

interface s256_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface s256_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// Top level of the byte-serial SHA-256 hasher: request queue plus hashing core.
// Depends on s256_pkg, s256_if, s256_front and s256_core.
`default_nettype none

//  Channel   Role     Payload
//  msg       sink     data_byte[7:0], has_byte, end_of_message
//  digest    source   digest_word[31:0], word_index[2:0], last_word
//
//  The core writes each message byte that it takes into the block buffer. A
//  full block then holds the core for 64 rounds in the single round unit and
//  one chaining add. Ending a message takes a setup state, then pads each
//  byte position left in a final block (up to 64, one or two blocks), each
//  block followed by its compression, then eight words out at one per cycle
//  while the receiver is ready.
//  The front queue keeps taking requests while the core is busy until it
//  fills; reset clears all control state and loads the initial hash values.

module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    s256_msg_if.sink   msg,
    s256_dig_if.source digest
);
    s256_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    // Requests with neither flag set are dropped here; the rest wait in order.
    s256_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    // The core takes one queued request per cycle when it is collecting bytes.
    s256_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .dig        (digest)
    );
endmodule

`default_nettype wire

### rtl/s256_front.sv
// Front end: accepts requests, drops empty ones, and queues the rest.
// Depends on s256_pkg and s256_msg_if.
`default_nettype none

module s256_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    s256_msg_if.sink           msg,
    output s256_pkg::item_t    item,
    output logic               item_valid,
    input  wire logic          item_ready
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    s256_pkg::item_t q_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push, pop;

    assign msg.ready  = (count_reg != CW'(QUEUE_DEPTH));
    // A request with neither flag changes nothing and is not queued.
    assign push       = msg.valid && msg.ready && (msg.has_byte || msg.end_of_message);
    assign item_valid = (count_reg != '0);
    assign pop        = item_valid && item_ready;
    assign item       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data_byte: msg.data_byte, has_byte: msg.has_byte,
                                   end_of_message: msg.end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

`default_nettype wire

### rtl/s256_core.sv
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on s256_pkg and s256_dig_if.
`default_nettype none

module s256_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  s256_pkg::item_t    item,
    input  wire logic          item_valid,
    output logic               item_ready,
    s256_dig_if.source         dig
);
    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_PADINIT = 3'd1;
    localparam logic [2:0] S_PAD     = 3'd2;
    localparam logic [2:0] S_ROUND   = 3'd3;
    localparam logic [2:0] S_FINAL   = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0]  state_reg;
    logic [6:0]  fill_reg;
    logic [63:0] bits_reg, total_reg;
    logic        two_blk_reg, first_reg, pend_end_reg, pad_mode_reg, final_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] chain_reg [8];

    logic [31:0] t1, t2, new_w;
    logic [5:0]  pos;
    logic [7:0]  pad_byte;
    logic        len_byte;
    logic        take;

    assign item_ready = (state_reg == S_COLLECT);
    assign take       = item_valid && item_ready;
    assign pos        = fill_reg[5:0];

    // The length goes into the last eight bytes of the final block only.
    assign len_byte = !first_reg && !two_blk_reg && (pos >= s256_pkg::LEN_POS);
    assign pad_byte = first_reg ? s256_pkg::PAD_MARK : (len_byte ? total_reg[63:56] : 8'h00);

    assign t1 = v_reg[7] + s256_pkg::big_sig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + s256_pkg::round_k(round_reg) + w_reg[0];
    assign t2 = s256_pkg::big_sig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign new_w = s256_pkg::small_sig1(w_reg[14]) + w_reg[9]
                 + s256_pkg::small_sig0(w_reg[1]) + w_reg[0];

    assign dig.valid       = (state_reg == S_EMIT);
    assign dig.digest_word = chain_reg[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == 3'd7);

    // Buffer words and working variables carry no reset.
    always_ff @(posedge clk)
    begin
        if (take && item.has_byte)
        begin
            w_reg[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.data_byte;
        end
        else if (state_reg == S_PAD)
        begin
            w_reg[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= pad_byte;
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= new_w;
        end

        if (state_reg == S_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_COLLECT;
            fill_reg     <= '0;
            bits_reg     <= '0;
            total_reg    <= '0;
            two_blk_reg  <= 1'b0;
            first_reg    <= 1'b0;
            pend_end_reg <= 1'b0;
            pad_mode_reg <= 1'b0;
            final_reg    <= 1'b0;
            round_reg    <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= s256_pkg::INIT_H[i];
            end
        end
        else
        begin
            unique case (state_reg)
                S_COLLECT:
                begin
                    if (take)
                    begin
                        if (item.has_byte && pos == 6'd63)
                        begin
                            fill_reg     <= '0;
                            bits_reg     <= bits_reg + s256_pkg::BLOCK_BITS;
                            pend_end_reg <= item.end_of_message;
                            final_reg    <= 1'b0;
                            round_reg    <= '0;
                            state_reg    <= S_ROUND;
                        end
                        else
                        begin
                            if (item.has_byte)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            if (item.end_of_message)
                            begin
                                state_reg <= S_PADINIT;
                            end
                        end
                    end
                end
                S_PADINIT:
                begin
                    total_reg    <= bits_reg + {54'd0, fill_reg, 3'd0};
                    two_blk_reg  <= (pos >= s256_pkg::LEN_POS);
                    first_reg    <= 1'b1;
                    pend_end_reg <= 1'b0;
                    pad_mode_reg <= 1'b1;
                    state_reg    <= S_PAD;
                end
                S_PAD:
                begin
                    first_reg <= 1'b0;
                    if (len_byte)
                    begin
                        total_reg <= {total_reg[55:0], 8'h00};
                    end
                    if (pos == 6'd63)
                    begin
                        fill_reg    <= '0;
                        final_reg   <= !two_blk_reg;
                        two_blk_reg <= 1'b0;
                        round_reg   <= '0;
                        state_reg   <= S_ROUND;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    priority if (final_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (pad_mode_reg)
                    begin
                        state_reg <= S_PAD;
                    end
                    else if (pend_end_reg)
                    begin
                        state_reg <= S_PADINIT;
                    end
                    else
                    begin
                        state_reg <= S_COLLECT;
                    end
                end
                S_EMIT:
                begin
                    if (dig.ready)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= s256_pkg::INIT_H[i];
                            end
                            fill_reg     <= '0;
                            bits_reg     <= '0;
                            pad_mode_reg <= 1'b0;
                            final_reg    <= 1'b0;
                            state_reg    <= S_COLLECT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

### rtl/s256_checker.sv
// Port-level checks on the digest channel of the hasher, bound to the top level.
// Depends on assert_macros.svh and sha256_stream_hasher.
`default_nettype none
`include "assert_macros.svh"

module s256_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    logic [2:0] exp_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_idx_reg <= exp_idx_reg + 1'b1;
        end
    end

    `S256_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word))
    `S256_ASSERT_IMP(a_order, out_valid, word_index == exp_idx_reg)
    `S256_ASSERT_IMP(a_last, out_valid, last_word == (word_index == 3'd7))
    `S256_ASSERT(a_first, $rose(out_valid) |-> word_index == 3'd0)
endmodule

bind sha256_stream_hasher s256_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
);

`default_nettype wire

### test/hasher_scoreboard.sv
// Digest predictor and scoreboard for the byte-serial SHA-256 hasher.
// Depends on s256_pkg for the initial hash values and the padding constants.

class hasher_scoreboard;
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    logic [31:0]   chain[8];
    logic [7:0]    buffer[64];
    int unsigned   fill;
    logic [63:0]   bit_count;
    digest_entry_t pending_words[$];
    int unsigned   mismatches;
    int unsigned   words_checked;
    int unsigned   messages_done;

    function new();
        mismatches = 0;
        words_checked = 0;
        messages_done = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++)
            chain[i] = s256_pkg::INIT_H[i];
        for (int i = 0; i < 64; i++)
            buffer[i] = 8'h00;
        fill = 0;
        bit_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] kconst(int t);
        logic [31:0] k[64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = chain;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    // Notes one accepted request and queues the digest words it produces.
    function void note_request(logic [7:0] data, logic has_byte, logic eom);
        logic [63:0]   total;
        digest_entry_t e;
        if (has_byte)
        begin
            buffer[fill] = data;
            fill++;
            if (fill == 64)
            begin
                compress();
                bit_count += s256_pkg::BLOCK_BITS;
                fill = 0;
            end
        end
        if (!eom)
            return;
        total = bit_count + 64'(fill) * 8;
        buffer[fill] = s256_pkg::PAD_MARK;
        fill++;
        if (fill > s256_pkg::LEN_POS)
        begin
            while (fill < 64)
                buffer[fill++] = 8'h00;
            compress();
            fill = 0;
        end
        while (fill < s256_pkg::LEN_POS)
            buffer[fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            buffer[s256_pkg::LEN_POS + i] = total[63 - 8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            e.word = chain[i];
            e.index = 3'(i);
            e.last = (i == 7);
            pending_words = {pending_words, e};
        end
        messages_done++;
        restart();
    endfunction

    // Checks one accepted digest word against the oldest expectation.
    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
        digest_entry_t e;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h index %0d", word, index);
            return;
        end
        e = pending_words.pop_front();
        words_checked++;
        if (word !== e.word || index !== e.index || last !== e.last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                         e.word, e.index, e.last, word, index, last);
        end
    endfunction
endclass

### test/testbench.sv
// Top-level testbench of sha256_stream_hasher: drives messages, checks digests.
// Depends on s256_pkg, s256_if, hasher_scoreboard.sv and the RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Worst case per request: a full block compression plus padding and eight
    // words; the limit allows for this many times over with random stalls.
    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    int unsigned cycle_count;
    int unsigned requests_sent;
    bit sink_hold;      // long receiver hold-off, driven by its own process
    bit sink_calm;      // stretch with no random receiver stalls
    bit source_calm;

    s256_msg_if msg();
    s256_dig_if digest();

    sha256_stream_hasher dut (
        .clk(clk),
        .rst_n(rst_n),
        .msg(msg.sink),
        .digest(digest.source)
    );

    hasher_scoreboard digest_board;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver side: ready changes at the falling edge, roughly 7 percent
    // stall unless a calm stretch or a long hold-off is in force.
    always @(negedge clk)
    begin
        if (!rst_n)
            digest.ready <= 1'b0;
        else if (sink_hold)
            digest.ready <= 1'b0;
        else
            digest.ready <= sink_calm || ($urandom_range(99) >= 7);
    end

    // Every accepted digest word is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && digest.valid && digest.ready)
            digest_board.check_word(digest.digest_word, digest.word_index, digest.last_word);
    end

    // Offers one request and holds it until accepted. Valid stays high after
    // the acceptance, so the next request follows without a gap; random idle
    // cycles drop it before the next offer, and source_idle drops it when the
    // sender stops.
    task automatic send_request(input logic [7:0] data, input logic has_byte,
                                input logic eom);
        while (!source_calm && $urandom_range(99) < 7)
        begin
            msg.valid <= 1'b0;
            @(negedge clk);
        end
        msg.valid <= 1'b1;
        msg.data_byte <= data;
        msg.has_byte <= has_byte;
        msg.end_of_message <= eom;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        digest_board.note_request(data, has_byte, eom);
        requests_sent++;
        @(negedge clk);
    endtask

    // Withdraws the offer; called at a falling edge when the sender pauses.
    task automatic source_idle();
        msg.valid <= 1'b0;
    endtask

    // Sends a message of random bytes; the end either rides on the last byte
    // or comes as a separate request with no byte.
    task automatic send_message(input int unsigned length);
        bit separate_end;
        separate_end = (length == 0) || $urandom_range(1);
        for (int i = 0; i < length; i++)
            send_request(8'($urandom_range(255)), 1'b1,
                         !separate_end && (i == length - 1));
        if (separate_end)
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        source_idle();
        while (digest_board.pending_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned length;
        bit skip_message;
        digest_board = new();
        cycle_count = 0;
        requests_sent = 0;
        sink_hold = 1'b0;
        sink_calm = 1'b0;
        source_calm = 1'b0;
        length = 0;
        skip_message = 1'b0;
        rst_n = 1'b0;
        msg.valid = 1'b0;
        msg.data_byte = 8'h00;
        msg.has_byte = 1'b0;
        msg.end_of_message = 1'b0;
        digest.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: the empty message, a request with neither flag
        // (ignored, with a stray data byte), the extreme byte values, the end
        // on its own and together with a byte, and the lengths around the
        // padding boundary where one or two final blocks result.
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'haa, 1'b1, 1'b1);
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h80, 1'b1, 1'b1);
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);

        // Pause the sender until every digest word has come back.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering requests,
        // so the output and the front queue fill and the input stalls.
        fork
            begin
                sink_hold = 1'b1;
                repeat (600) @(posedge clk);
                sink_hold = 1'b0;
            end
            begin
                for (int m = 0; m < 6; m++)
                    send_message($urandom_range(3));
                source_idle();
            end
        join
        @(negedge clk);

        // Random part: mostly well-formed messages of random length, some
        // with the end on a byte, some ended alone, plus ignored requests.
        while (requests_sent < 420)
        begin
            sink_calm = (requests_sent >= 250 && requests_sent < 330);
            source_calm = sink_calm;
            skip_message = 1'b0;
            case ($urandom_range(9))
                0:
                begin
                    send_request(8'($urandom_range(255)), 1'b0, 1'b0);
                    skip_message = 1'b1;
                end
                1:       length = $urandom_range(130, 64);
                default: length = $urandom_range(12);
            endcase
            if (!skip_message)
                send_message(length);
        end
        sink_calm = 1'b0;
        source_calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d messages, %0d digest words checked",
                 requests_sent, digest_board.messages_done, digest_board.words_checked);
        $display("includes empty, padding-boundary and multi-block messages, and stalls");
        if (digest_board.mismatches == 0 && digest_board.pending_words.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
